@@ rtl/core/slmf_pkg.sv @@
// Shared constants, codes and control structs for the stereo meter ballistics.
// Depends on nothing; every other file in rtl/core imports it.
`default_nettype none

package slmf_pkg;

   localparam int LEVEL_BITS_DEF = 12;
   localparam int TIMER_BITS_DEF = 16;

   localparam int LVL_W       = 12;   // width of max_level and of the level inside the fall arithmetic
   localparam int STEP_W      = 7;
   localparam int PERIOD_W    = 16;
   localparam int FRAC_W      = 16;
   localparam int FRAC_BITS   = 14;
   localparam int OP_W        = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   // level*base_step/100 as (level * base_step*RECIP_K) >> RECIP_SHIFT, exact below 2**20
   localparam int RECIP_SHIFT = 27;
   localparam int STEPK_W     = 28;
   localparam logic [STEPK_W-1:0] RECIP_K = STEPK_W'(((64'd1 << RECIP_SHIFT) + 64'd99) / 64'd100);

   localparam logic [LVL_W-1:0]    MAX_LEVEL_RST  = LVL_W'(100);
   localparam logic [STEP_W-1:0]   BASE_STEP_RST  = STEP_W'(3);
   localparam logic [PERIOD_W-1:0] FALL_MS_RST    = PERIOD_W'(40);
   localparam logic [PERIOD_W-1:0] HOLD_MS_RST    = PERIOD_W'(1000);
   localparam logic                SHOW_PEAK_RST  = 1'b1;
   localparam logic                HAS_RECORD_RST = 1'b0;
   localparam logic                STEREO_RST     = 1'b1;

   typedef enum logic [OP_W-1:0] {
      OP_PLAY = 2'd0,
      OP_REC  = 2'd1,
      OP_TICK = 2'd2
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_LEVEL  = 3'd0,
      CSR_BASE_STEP  = 3'd1,
      CSR_FALL_MS    = 3'd2,
      CSR_HOLD_MS    = 3'd3,
      CSR_SHOW_PEAK  = 3'd4,
      CSR_HAS_RECORD = 3'd5,
      CSR_STEREO     = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic upd_play;
      logic upd_rec;
      logic tick;
      logic timers_on;
      logic show_peak;
   } lane_cmd_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] fall_ms;
      logic [PERIOD_W-1:0] hold_ms;
      logic [STEPK_W-1:0]  step_k;
   } lane_cfg_type;

endpackage

`default_nettype wire

@@ rtl/core/slmf_scale.sv @@
// Scales a signed Q2.14 fraction by the full-scale level and clamps it.
// Depends on slmf_pkg.
`default_nettype none

module slmf_scale #(
   parameter int LEVEL_BITS = slmf_pkg::LEVEL_BITS_DEF
) (
   input  wire logic signed [slmf_pkg::FRAC_W-1:0] frac,
   input  wire logic [slmf_pkg::LVL_W-1:0]         full,
   output logic [LEVEL_BITS-1:0]                   level
);
   import slmf_pkg::*;

   localparam int PROD_W = FRAC_W + LVL_W + 1;
   localparam int CMP_W  = (LEVEL_BITS > LVL_W) ? LEVEL_BITS : LVL_W;
   localparam logic [CMP_W-1:0] LMASK = CMP_W'((64'd1 << LEVEL_BITS) - 64'd1);

   logic signed [PROD_W-1:0] prod;
   logic                     pos;
   logic [LVL_W+1:0]         raw;
   logic [LVL_W-1:0]         vf;
   logic [CMP_W-1:0]         vw;

   always_comb begin
      prod = $signed({1'b0, full}) * frac;
      pos  = !prod[PROD_W-1] && (prod != '0);
      raw  = prod[FRAC_BITS +: LVL_W+2];
      if (!pos) begin
         vf = '0;
      end else if (raw > {2'b00, full}) begin
         vf = full;
      end else begin
         vf = raw[LVL_W-1:0];
      end
      vw    = CMP_W'(vf);
      level = (vw > LMASK) ? LEVEL_BITS'(LMASK) : LEVEL_BITS'(vw);
   end

endmodule

`default_nettype wire

@@ rtl/core/slmf_fall.sv @@
// One fall step: level - (level*base_step/100 + 1), floored at zero.
// Depends on slmf_pkg.
`default_nettype none

module slmf_fall #(
   parameter int LEVEL_BITS = slmf_pkg::LEVEL_BITS_DEF
) (
   input  wire logic [LEVEL_BITS-1:0]        level,
   input  wire logic [slmf_pkg::STEPK_W-1:0] step_k,
   output logic [LEVEL_BITS-1:0]             level_out
);
   import slmf_pkg::*;

   localparam int PROD_W = LVL_W + STEPK_W;
   localparam int Q_W    = PROD_W - RECIP_SHIFT;

   logic [LVL_W-1:0]  lv;
   logic [PROD_W-1:0] prod;
   logic [Q_W:0]      step;

   always_comb begin
      lv   = LVL_W'(level);
      prod = PROD_W'(lv) * PROD_W'(step_k);
      step = (Q_W+1)'(prod[RECIP_SHIFT +: Q_W]) + (Q_W+1)'(1);
      if (lv == '0 || step >= (Q_W+1)'(lv)) begin
         level_out = '0;
      end else begin
         level_out = LEVEL_BITS'(lv - LVL_W'(step));
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/slmf_lane.sv @@
// One meter channel: play/record levels, held peak, fall and peak-hold timers.
// Depends on slmf_pkg and slmf_fall.
`default_nettype none

module slmf_lane #(
   parameter int LEVEL_BITS = slmf_pkg::LEVEL_BITS_DEF,
   parameter int TIMER_BITS = slmf_pkg::TIMER_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire slmf_pkg::lane_cmd_type cmd,
   input  wire slmf_pkg::lane_cfg_type cfg,
   input  wire logic [LEVEL_BITS-1:0]  level,
   output logic [LEVEL_BITS-1:0]       play_next,
   output logic [LEVEL_BITS-1:0]       rec_next,
   output logic [LEVEL_BITS-1:0]       peak_next,
   output logic                        falling_next
);
   import slmf_pkg::*;

   localparam int CW = (TIMER_BITS + 1 > PERIOD_W) ? TIMER_BITS + 1 : PERIOD_W;

   logic [LEVEL_BITS-1:0] lvl_ff, lvl_in, rec_ff, rec_in, pk_ff, pk_in;
   logic                  fall_run_ff, fall_run_in, hold_run_ff, hold_run_in;
   logic [TIMER_BITS-1:0] fall_cnt_ff, fall_cnt_in, hold_cnt_ff, hold_cnt_in;

   logic [LEVEL_BITS-1:0] fall_lvl, fall_rec;
   logic [TIMER_BITS:0]   fall_nxt, hold_nxt;
   logic [PERIOD_W-1:0]   fall_per, hold_per;
   logic                  fall_hit, hold_hit;

   slmf_fall #(.LEVEL_BITS(LEVEL_BITS)) u_fall_play (
      .level(lvl_ff), .step_k(cfg.step_k), .level_out(fall_lvl)
   );

   slmf_fall #(.LEVEL_BITS(LEVEL_BITS)) u_fall_rec (
      .level(rec_ff), .step_k(cfg.step_k), .level_out(fall_rec)
   );

   always_comb begin
      fall_per = (cfg.fall_ms == '0) ? PERIOD_W'(1) : cfg.fall_ms;
      hold_per = (cfg.hold_ms == '0) ? PERIOD_W'(1) : cfg.hold_ms;
      fall_nxt = (TIMER_BITS+1)'(fall_cnt_ff) + (TIMER_BITS+1)'(1);
      hold_nxt = (TIMER_BITS+1)'(hold_cnt_ff) + (TIMER_BITS+1)'(1);
      fall_hit = fall_run_ff && (CW'(fall_nxt) >= CW'(fall_per) || fall_cnt_ff == '1);
      hold_hit = hold_run_ff && (CW'(hold_nxt) >= CW'(hold_per) || hold_cnt_ff == '1);

      lvl_in      = lvl_ff;
      rec_in      = rec_ff;
      pk_in       = pk_ff;
      fall_run_in = fall_run_ff;
      fall_cnt_in = fall_cnt_ff;
      hold_run_in = hold_run_ff;
      hold_cnt_in = hold_cnt_ff;

      if (cmd.upd_play || cmd.upd_rec) begin
         if (cmd.upd_rec) begin
            rec_in = level;
         end else begin
            lvl_in = level;
         end
         if (level != '0 && cmd.timers_on && !fall_run_ff) begin
            fall_run_in = 1'b1;
            fall_cnt_in = '0;
         end
         if (cmd.upd_play && cmd.show_peak && level >= pk_ff) begin
            pk_in = level;
            if (cmd.timers_on) begin
               hold_run_in = 1'b1;
               hold_cnt_in = '0;
            end
         end
      end else if (cmd.tick && cmd.timers_on) begin
         if (hold_run_ff) begin
            hold_cnt_in = hold_hit ? '0 : hold_nxt[TIMER_BITS-1:0];
         end
         if (hold_hit) begin
            pk_in = '0;
         end
         if (fall_run_ff) begin
            if (fall_hit) begin
               fall_cnt_in = '0;
               lvl_in      = fall_lvl;
               rec_in      = fall_rec;
               if (fall_lvl == '0) begin
                  pk_in = '0;
               end
               if (fall_lvl == '0 && fall_rec == '0) begin
                  fall_run_in = 1'b0;
               end
            end else begin
               fall_cnt_in = fall_nxt[TIMER_BITS-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lvl_ff      <= '0;
         rec_ff      <= '0;
         pk_ff       <= '0;
         fall_run_ff <= 1'b0;
         fall_cnt_ff <= '0;
         hold_run_ff <= 1'b0;
         hold_cnt_ff <= '0;
      end else begin
         lvl_ff      <= lvl_in;
         rec_ff      <= rec_in;
         pk_ff       <= pk_in;
         fall_run_ff <= fall_run_in;
         fall_cnt_ff <= fall_cnt_in;
         hold_run_ff <= hold_run_in;
         hold_cnt_ff <= hold_cnt_in;
      end
   end

   assign play_next    = lvl_in;
   assign rec_next     = rec_in;
   assign peak_next    = pk_in;
   assign falling_next = fall_run_in;

endmodule

`default_nettype wire

@@ rtl/core/stereo_level_meter_fall_peak_hold_unit.sv @@
// Top level of the stereo meter ballistics: registers, scaling, two lanes, result register.
// Depends on slmf_pkg, slmf_scale and slmf_lane.
//
//   port group  direction  carries
//   req_*       in         one item: op, left_level, right_level
//   rsp_*       out        one item per request: levels, held peaks, fall flags
//   csr_*       in         register writes: index and data
//
// Each item is taken on a req handshake and its result sits in the output register the cycle
// after; a new item may be taken every cycle while that register is empty or being drained.
// The result is held in the single result register behind the two lane updates.
// Reset clears levels, peaks and timers and loads register defaults. csr_ready is always high.
`default_nettype none

module stereo_level_meter_fall_peak_hold_unit #(
   parameter int LEVEL_BITS = slmf_pkg::LEVEL_BITS_DEF,
   parameter int TIMER_BITS = slmf_pkg::TIMER_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,

   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [slmf_pkg::OP_W-1:0]          req_op,
   input  wire logic signed [slmf_pkg::FRAC_W-1:0] req_left_level,
   input  wire logic signed [slmf_pkg::FRAC_W-1:0] req_right_level,

   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [LEVEL_BITS-1:0]                   rsp_play_left,
   output logic [LEVEL_BITS-1:0]                   rsp_play_right,
   output logic [LEVEL_BITS-1:0]                   rsp_rec_left,
   output logic [LEVEL_BITS-1:0]                   rsp_rec_right,
   output logic [LEVEL_BITS-1:0]                   rsp_held_left,
   output logic [LEVEL_BITS-1:0]                   rsp_held_right,
   output logic                                    rsp_falling_left,
   output logic                                    rsp_falling_right,

   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [slmf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [slmf_pkg::CSR_DATA_W-1:0]    csr_data
);
   import slmf_pkg::*;

   logic [LVL_W-1:0]    max_level_ff;
   logic [STEPK_W-1:0]  step_k_ff;
   logic [PERIOD_W-1:0] fall_ms_ff, hold_ms_ff;
   logic                show_peak_ff, has_record_ff, stereo_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_BITS-1:0] play_l_ff, play_r_ff, rec_l_ff, rec_r_ff, held_l_ff, held_r_ff;
   logic                fall_l_ff, fall_r_ff;

   logic                accept;
   logic [LEVEL_BITS-1:0] lvl_l, lvl_r;
   logic [LEVEL_BITS-1:0] play_l_in, play_r_in, rec_l_in, rec_r_in, held_l_in, held_r_in;
   logic                fall_l_in, fall_r_in;
   lane_cmd_type        cmd_l, cmd_r;
   lane_cfg_type        cfg;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_level_ff  <= MAX_LEVEL_RST;
         step_k_ff     <= STEPK_W'(BASE_STEP_RST) * RECIP_K;
         fall_ms_ff    <= FALL_MS_RST;
         hold_ms_ff    <= HOLD_MS_RST;
         show_peak_ff  <= SHOW_PEAK_RST;
         has_record_ff <= HAS_RECORD_RST;
         stereo_ff     <= STEREO_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MAX_LEVEL:  max_level_ff  <= csr_data[LVL_W-1:0];
            CSR_BASE_STEP:  step_k_ff     <= STEPK_W'(csr_data[STEP_W-1:0]) * RECIP_K;
            CSR_FALL_MS:    fall_ms_ff    <= csr_data[PERIOD_W-1:0];
            CSR_HOLD_MS:    hold_ms_ff    <= csr_data[PERIOD_W-1:0];
            CSR_SHOW_PEAK:  show_peak_ff  <= csr_data[0];
            CSR_HAS_RECORD: has_record_ff <= csr_data[0];
            CSR_STEREO:     stereo_ff     <= csr_data[0];
            default: ;
         endcase
      end
   end

   slmf_scale #(.LEVEL_BITS(LEVEL_BITS)) u_scale_l (
      .frac(req_left_level), .full(max_level_ff), .level(lvl_l)
   );

   slmf_scale #(.LEVEL_BITS(LEVEL_BITS)) u_scale_r (
      .frac(req_right_level), .full(max_level_ff), .level(lvl_r)
   );

   always_comb begin
      cmd_l.upd_play  = accept && (req_op == OP_PLAY);
      cmd_l.upd_rec   = accept && (req_op == OP_REC) && has_record_ff;
      cmd_l.tick      = accept && (req_op == OP_TICK);
      cmd_l.timers_on = 1'b1;
      cmd_l.show_peak = show_peak_ff;
      cmd_r           = cmd_l;
      cmd_r.timers_on = stereo_ff;
      cfg.fall_ms     = fall_ms_ff;
      cfg.hold_ms     = hold_ms_ff;
      cfg.step_k      = step_k_ff;
   end

   slmf_lane #(.LEVEL_BITS(LEVEL_BITS), .TIMER_BITS(TIMER_BITS)) u_lane_l (
      .clock(clock), .reset(reset), .cmd(cmd_l), .cfg(cfg), .level(lvl_l),
      .play_next(play_l_in), .rec_next(rec_l_in), .peak_next(held_l_in),
      .falling_next(fall_l_in)
   );

   slmf_lane #(.LEVEL_BITS(LEVEL_BITS), .TIMER_BITS(TIMER_BITS)) u_lane_r (
      .clock(clock), .reset(reset), .cmd(cmd_r), .cfg(cfg), .level(lvl_r),
      .play_next(play_r_in), .rec_next(rec_r_in), .peak_next(held_r_in),
      .falling_next(fall_r_in)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // merge both lanes into the result register
   always_ff @(posedge clock) begin
      if (accept) begin
         play_l_ff <= play_l_in;
         play_r_ff <= play_r_in;
         rec_l_ff  <= rec_l_in;
         rec_r_ff  <= rec_r_in;
         held_l_ff <= held_l_in;
         held_r_ff <= held_r_in;
         fall_l_ff <= fall_l_in;
         fall_r_ff <= fall_r_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_play_left     = play_l_ff;
   assign rsp_play_right    = play_r_ff;
   assign rsp_rec_left      = rec_l_ff;
   assign rsp_rec_right     = rec_r_ff;
   assign rsp_held_left     = held_l_ff;
   assign rsp_held_right    = held_r_ff;
   assign rsp_falling_left  = fall_l_ff;
   assign rsp_falling_right = fall_r_ff;

endmodule

`default_nettype wire
